>>> sv/thcm_pkg.sv
// Shared types, codes and calibration constants of the thruster command mixer.
package thcm_pkg;

   // Command kinds
   localparam logic [1:0] MODE_FORWARD  = 2'd0;
   localparam logic [1:0] MODE_SIDEWARD = 2'd1;
   localparam logic [1:0] MODE_UPWARD   = 2'd2;
   localparam logic [1:0] MODE_TURN     = 2'd3;

   // Thruster pairs
   localparam logic [1:0] PAIR_EAST_WEST = 2'd0;
   localparam logic [1:0] PAIR_SWAY      = 2'd1;
   localparam logic [1:0] PAIR_VERTICAL  = 2'd2;

   // Control register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_UPWARD        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOUTH_UP_BIAS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SIDEWARD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FORWARD       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TURN_FORWARD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TURN_SIDEWARD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BUOYANCY_OFFSET   = 3'd6;

   // Scale factors applied before the divide by 255
   localparam logic [6:0] K_UPWARD = 7'd73;
   localparam logic [6:0] K_OTHER  = 7'd53;
   // Reciprocal of 255 in Q0.16, one low; corrected afterward
   localparam logic [8:0] RECIP_255 = 9'd257;

   // Shared multiply-add unit widths
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 15;
   localparam int MUL_C_W = 22;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

   // Calibration selectors
   localparam int CAL_SEL_W = 3;
   localparam logic [CAL_SEL_W-1:0] CAL_EAST       = 3'd0;
   localparam logic [CAL_SEL_W-1:0] CAL_WEST       = 3'd1;
   localparam logic [CAL_SEL_W-1:0] CAL_NORTH_SWAY = 3'd2;
   localparam logic [CAL_SEL_W-1:0] CAL_SOUTH_SWAY = 3'd3;
   localparam logic [CAL_SEL_W-1:0] CAL_NORTH_UP   = 3'd4;
   localparam logic [CAL_SEL_W-1:0] CAL_SOUTH_UP   = 3'd5;

   typedef logic [MUL_A_W-1:0] cal_gain_type;
   typedef logic [MUL_C_W-1:0] cal_offset_type;

   // Linear calibration duty' = (A + B * duty) >> 16, Q8.16; west passes through.
   function automatic cal_offset_type cal_offset(input logic [CAL_SEL_W-1:0] sel);
      cal_offset_type result;
      case (sel)
         CAL_EAST:       result = 22'd2684998;
         CAL_WEST:       result = 22'd0;
         CAL_NORTH_SWAY: result = 22'd2757165;
         CAL_SOUTH_SWAY: result = 22'd3349270;
         CAL_NORTH_UP:   result = 22'd944540;
         CAL_SOUTH_UP:   result = 22'd1143962;
         default:        result = 22'd0;
      endcase
      return result;
   endfunction

   function automatic cal_gain_type cal_gain(input logic [CAL_SEL_W-1:0] sel);
      cal_gain_type result;
      case (sel)
         CAL_EAST:       result = 17'd67020;
         CAL_WEST:       result = 17'd65536;
         CAL_NORTH_SWAY: result = 17'd52545;
         CAL_SOUTH_SWAY: result = 17'd60615;
         CAL_NORTH_UP:   result = 17'd58615;
         CAL_SOUTH_UP:   result = 17'd60823;
         default:        result = 17'd65536;
      endcase
      return result;
   endfunction

endpackage

>>> sv/thcm_req_if.sv
// Command channel: valid/ready handshake carrying one motion command.
interface thcm_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic signed [8:0] magnitude;

   modport source (output valid, output mode, output magnitude, input ready);
   modport sink   (input valid, input mode, input magnitude, output ready);
endinterface

>>> sv/thcm_rsp_if.sv
// Result channel: valid/ready handshake carrying one thruster pair drive.
interface thcm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] thruster_pair;
   logic [7:0] first_duty_inverted;
   logic       first_direction;
   logic [7:0] second_duty_inverted;
   logic       second_direction;

   modport source (output valid, output thruster_pair, output first_duty_inverted,
                   output first_direction, output second_duty_inverted,
                   output second_direction, input ready);
   modport sink   (input valid, input thruster_pair, input first_duty_inverted,
                   input first_direction, input second_duty_inverted,
                   input second_direction, output ready);
endinterface

>>> sv/thruster_command_mixer_core.sv
// Thruster command mixer top level: command front end, step sequencer, result register.
//
// Each motion command (forward, sideward, upward or turn) is turned into a thruster
// pair, two directions and two inverted duties. On its transfer a command is latched
// and its pair, directions and minimum are chosen; then it passes through five
// sequencer steps around one shared multiply-add unit (scale by 73 or 53,
// reciprocal multiply for the divide by 255, correction and minimum add, then the
// east/north and west/south calibrations), after which the next command can be taken.
// The command channel is ready only while the sequencer is idle. The result sits in
// an output register, so a new command is taken while the previous result still
// waits; the last step stalls only if that register is still full. The moving-forward
// flag resets to one and is updated when a command is taken. Control registers are to
// be written through the csr port while no command is in flight; the block itself
// does not enforce this.
module thruster_command_mixer_core #(
   parameter int DUTY_MAX = 255
) (
   input  logic                              clock,
   input  logic                              reset,
   thcm_req_if.sink                          req_ch,
   thcm_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_en,
   input  logic [thcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [thcm_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int DW = $clog2(DUTY_MAX + 1);
   localparam int AW = 12;   // signed width of calibrated duty plus bias

   // Sequencer codes
   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_SCALE      = 3'd1;
   localparam logic [2:0] ST_RECIP      = 3'd2;
   localparam logic [2:0] ST_SUM        = 3'd3;
   localparam logic [2:0] ST_CAL_FIRST  = 3'd4;
   localparam logic [2:0] ST_CAL_SECOND = 3'd5;

   // ---------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------
   logic [7:0]        min_upward_ff;
   logic signed [8:0] south_up_bias_ff;
   logic [7:0]        min_sideward_ff;
   logic [7:0]        min_forward_ff;
   logic [7:0]        min_turn_forward_ff;
   logic [7:0]        min_turn_sideward_ff;
   logic signed [8:0] buoyancy_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_upward_ff        <= 8'd80;
         south_up_bias_ff     <= -9'sd35;
         min_sideward_ff      <= 8'd147;
         min_forward_ff       <= 8'd147;
         min_turn_forward_ff  <= 8'd60;
         min_turn_sideward_ff <= 8'd80;
         buoyancy_offset_ff   <= 9'sd0;
      end else if (csr_write_en) begin
         case (csr_index)
            thcm_pkg::CSR_MIN_UPWARD:        min_upward_ff        <= csr_write_data[7:0];
            thcm_pkg::CSR_SOUTH_UP_BIAS:     south_up_bias_ff     <= $signed(csr_write_data);
            thcm_pkg::CSR_MIN_SIDEWARD:      min_sideward_ff      <= csr_write_data[7:0];
            thcm_pkg::CSR_MIN_FORWARD:       min_forward_ff       <= csr_write_data[7:0];
            thcm_pkg::CSR_MIN_TURN_FORWARD:  min_turn_forward_ff  <= csr_write_data[7:0];
            thcm_pkg::CSR_MIN_TURN_SIDEWARD: min_turn_sideward_ff <= csr_write_data[7:0];
            thcm_pkg::CSR_BUOYANCY_OFFSET:   buoyancy_offset_ff   <= $signed(csr_write_data);
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer, work and result registers
   // ---------------------------------------------------------------------------
   logic [2:0]                       state_ff, state_in;
   logic                             moving_forward_ff, moving_forward_in;
   logic [7:0]                       mag_ff, mag_in;
   logic [6:0]                       k_ff, k_in;
   logic [7:0]                       min_ff, min_in;
   logic [1:0]                       pair_ff, pair_in;
   logic                             dir_first_ff, dir_first_in;
   logic                             dir_second_ff, dir_second_in;
   logic [thcm_pkg::CAL_SEL_W-1:0]   cal_first_ff, cal_first_in;
   logic [thcm_pkg::CAL_SEL_W-1:0]   cal_second_ff, cal_second_in;
   logic                             bias_en_ff, bias_en_in;
   logic [14:0]                      prod_ff, prod_in;
   logic [6:0]                       quot_ff, quot_in;
   logic [8:0]                       sum_ff, sum_in;
   logic                             live_ff, live_in;
   logic [DW-1:0]                    duty_first_ff, duty_first_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [1:0]                       rsp_pair_ff, rsp_pair_in;
   logic [7:0]                       rsp_duty_first_ff, rsp_duty_first_in;
   logic                             rsp_dir_first_ff, rsp_dir_first_in;
   logic [7:0]                       rsp_duty_second_ff, rsp_duty_second_in;
   logic                             rsp_dir_second_ff, rsp_dir_second_in;

   // ---------------------------------------------------------------------------
   // Command front end: saturate, add buoyancy offset (upward only), take sign and magnitude
   // ---------------------------------------------------------------------------
   logic              req_xfer;
   logic signed [8:0] cmd_sat;
   logic signed [9:0] up_raw;
   logic signed [8:0] up_sat;
   logic signed [8:0] value;
   logic              cmd_pos;
   logic              value_pos;
   logic [8:0]        value_abs;

   assign req_xfer = req_ch.valid && req_ch.ready;

   always_comb begin
      // -256 is the only code outside +-255
      cmd_sat = (req_ch.magnitude == -9'sd256) ? -9'sd255 : req_ch.magnitude;
      up_raw  = 10'(cmd_sat) + 10'(buoyancy_offset_ff);
      if (up_raw > 10'sd255) begin
         up_sat = 9'sd255;
      end else if (up_raw < -10'sd255) begin
         up_sat = -9'sd255;
      end else begin
         up_sat = up_raw[8:0];
      end
      value     = (req_ch.mode == thcm_pkg::MODE_UPWARD) ? up_sat : cmd_sat;
      cmd_pos   = cmd_sat > 9'sd0;
      value_pos = value > 9'sd0;
      value_abs = value[8] ? 9'(-value) : 9'(value);
   end

   // ---------------------------------------------------------------------------
   // Shared multiply-add unit and its operand selection
   // ---------------------------------------------------------------------------
   logic [thcm_pkg::MUL_A_W-1:0]   mul_a;
   logic [thcm_pkg::MUL_B_W-1:0]   mul_b;
   logic [thcm_pkg::MUL_C_W-1:0]   mul_c;
   logic [thcm_pkg::MUL_P_W-1:0]   mul_res;
   logic [thcm_pkg::CAL_SEL_W-1:0] cal_sel;

   always_comb begin
      cal_sel = (state_ff == ST_CAL_SECOND) ? cal_second_ff : cal_first_ff;
      case (state_ff)
         ST_SCALE: begin
            mul_a = thcm_pkg::MUL_A_W'(mag_ff);
            mul_b = thcm_pkg::MUL_B_W'(k_ff);
            mul_c = '0;
         end
         ST_RECIP: begin
            mul_a = thcm_pkg::MUL_A_W'(thcm_pkg::RECIP_255);
            mul_b = prod_ff;
            mul_c = '0;
         end
         ST_CAL_FIRST, ST_CAL_SECOND: begin
            mul_a = thcm_pkg::cal_gain(cal_sel);
            mul_b = thcm_pkg::MUL_B_W'(sum_ff);
            mul_c = thcm_pkg::cal_offset(cal_sel);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
            mul_c = '0;
         end
      endcase
   end

   thcm_mul_acc u_mul_acc (
      .op_a   (mul_a),
      .op_b   (mul_b),
      .addend (mul_c),
      .result (mul_res)
   );

   // ---------------------------------------------------------------------------
   // Divide correction and duty clamp
   // ---------------------------------------------------------------------------
   logic [14:0]          quot_x255;
   logic [15:0]          rem;
   logic [7:0]           quot_fix;
   logic [9:0]           cal_q;
   logic signed [AW-1:0] duty_adj;
   logic [DW-1:0]        duty_now;
   logic [DW-1:0]        inv_first;
   logic [DW-1:0]        inv_second;
   logic [DW+7:0]        inv_first_wide;
   logic [DW+7:0]        inv_second_wide;
   logic                 rsp_free;

   always_comb begin
      // Reciprocal estimate is at most one low; the remainder tells
      quot_x255 = {quot_ff, 8'b0} - 15'(quot_ff);
      rem       = 16'(prod_ff) - 16'(quot_x255);
      quot_fix  = 8'(quot_ff) + ((rem >= 16'd255) ? 8'd1 : 8'd0);

      // Calibrated duty, bias on the south vertical thruster only
      cal_q    = mul_res[25:16];
      duty_adj = $signed(AW'(cal_q));
      if (bias_en_ff && state_ff == ST_CAL_SECOND) begin
         duty_adj = duty_adj + AW'(south_up_bias_ff);
      end
      if (!live_ff || duty_adj < $signed(AW'(0))) begin
         duty_now = '0;
      end else if (duty_adj > $signed(AW'(DUTY_MAX))) begin
         duty_now = DW'(DUTY_MAX);
      end else begin
         duty_now = duty_adj[DW-1:0];
      end

      inv_first       = DW'(DUTY_MAX) - duty_first_ff;
      inv_second      = DW'(DUTY_MAX) - duty_now;
      inv_first_wide  = (DW+8)'(inv_first);
      inv_second_wide = (DW+8)'(inv_second);
      rsp_free        = !rsp_valid_ff || rsp_ch.ready;
   end

   // ---------------------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in           = state_ff;
      moving_forward_in  = moving_forward_ff;
      mag_in             = mag_ff;
      k_in               = k_ff;
      min_in             = min_ff;
      pair_in            = pair_ff;
      dir_first_in       = dir_first_ff;
      dir_second_in      = dir_second_ff;
      cal_first_in       = cal_first_ff;
      cal_second_in      = cal_second_ff;
      bias_en_in         = bias_en_ff;
      prod_in            = prod_ff;
      quot_in            = quot_ff;
      sum_in             = sum_ff;
      live_in            = live_ff;
      duty_first_in      = duty_first_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ch.ready;
      rsp_pair_in        = rsp_pair_ff;
      rsp_duty_first_in  = rsp_duty_first_ff;
      rsp_dir_first_in   = rsp_dir_first_ff;
      rsp_duty_second_in = rsp_duty_second_ff;
      rsp_dir_second_in  = rsp_dir_second_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               // Latch the command and choose pair, directions and minimum
               mag_in        = value_abs[7:0];
               k_in          = thcm_pkg::K_OTHER;
               bias_en_in    = 1'b0;
               dir_first_in  = value_pos;
               dir_second_in = value_pos;
               case (req_ch.mode)
                  thcm_pkg::MODE_FORWARD: begin
                     pair_in       = thcm_pkg::PAIR_EAST_WEST;
                     min_in        = min_forward_ff;
                     cal_first_in  = thcm_pkg::CAL_EAST;
                     cal_second_in = thcm_pkg::CAL_WEST;
                     if (cmd_sat != 9'sd0) begin
                        moving_forward_in = 1'b1;
                     end
                  end
                  thcm_pkg::MODE_SIDEWARD: begin
                     pair_in       = thcm_pkg::PAIR_SWAY;
                     min_in        = min_sideward_ff;
                     cal_first_in  = thcm_pkg::CAL_NORTH_SWAY;
                     cal_second_in = thcm_pkg::CAL_SOUTH_SWAY;
                     if (cmd_sat != 9'sd0) begin
                        moving_forward_in = 1'b0;
                     end
                  end
                  thcm_pkg::MODE_UPWARD: begin
                     pair_in       = thcm_pkg::PAIR_VERTICAL;
                     min_in        = min_upward_ff;
                     k_in          = thcm_pkg::K_UPWARD;
                     cal_first_in  = thcm_pkg::CAL_NORTH_UP;
                     cal_second_in = thcm_pkg::CAL_SOUTH_UP;
                     bias_en_in    = 1'b1;
                  end
                  default: begin
                     // Turn: the pair depends on the last straight motion
                     if (moving_forward_ff) begin
                        pair_in       = thcm_pkg::PAIR_SWAY;
                        min_in        = min_turn_sideward_ff;
                        cal_first_in  = thcm_pkg::CAL_NORTH_SWAY;
                        cal_second_in = thcm_pkg::CAL_SOUTH_SWAY;
                        dir_first_in  = !cmd_pos;
                        dir_second_in = cmd_pos;
                     end else begin
                        pair_in       = thcm_pkg::PAIR_EAST_WEST;
                        min_in        = min_turn_forward_ff;
                        cal_first_in  = thcm_pkg::CAL_EAST;
                        cal_second_in = thcm_pkg::CAL_WEST;
                        dir_first_in  = cmd_pos;
                        dir_second_in = !cmd_pos;
                     end
                  end
               endcase
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_in  = mul_res[14:0];
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            quot_in  = mul_res[22:16];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = 9'(quot_fix) + 9'(min_ff);
            live_in  = quot_fix != 8'd0;
            state_in = ST_CAL_FIRST;
         end
         ST_CAL_FIRST: begin
            duty_first_in = duty_now;
            state_in      = ST_CAL_SECOND;
         end
         ST_CAL_SECOND: begin
            // Hold here until the result register frees up
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_pair_in        = pair_ff;
               rsp_duty_first_in  = inv_first_wide[7:0];
               rsp_dir_first_in   = dir_first_ff;
               rsp_duty_second_in = inv_second_wide[7:0];
               rsp_dir_second_in  = dir_second_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         moving_forward_ff <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         moving_forward_ff <= moving_forward_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      mag_ff             <= mag_in;
      k_ff               <= k_in;
      min_ff             <= min_in;
      pair_ff            <= pair_in;
      dir_first_ff       <= dir_first_in;
      dir_second_ff      <= dir_second_in;
      cal_first_ff       <= cal_first_in;
      cal_second_ff      <= cal_second_in;
      bias_en_ff         <= bias_en_in;
      prod_ff            <= prod_in;
      quot_ff            <= quot_in;
      sum_ff             <= sum_in;
      live_ff            <= live_in;
      duty_first_ff      <= duty_first_in;
      rsp_pair_ff        <= rsp_pair_in;
      rsp_duty_first_ff  <= rsp_duty_first_in;
      rsp_dir_first_ff   <= rsp_dir_first_in;
      rsp_duty_second_ff <= rsp_duty_second_in;
      rsp_dir_second_ff  <= rsp_dir_second_in;
   end

   // ---------------------------------------------------------------------------
   // Channel outputs
   // ---------------------------------------------------------------------------
   assign req_ch.ready                = (state_ff == ST_IDLE);
   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.thruster_pair        = rsp_pair_ff;
   assign rsp_ch.first_duty_inverted  = rsp_duty_first_ff;
   assign rsp_ch.first_direction      = rsp_dir_first_ff;
   assign rsp_ch.second_duty_inverted = rsp_duty_second_ff;
   assign rsp_ch.second_direction     = rsp_dir_second_ff;

endmodule

>>> sv/thcm_mul_acc.sv
// Shared unsigned multiply-add unit: product of two operands plus an addend.
module thcm_mul_acc (
   input  logic [thcm_pkg::MUL_A_W-1:0] op_a,
   input  logic [thcm_pkg::MUL_B_W-1:0] op_b,
   input  logic [thcm_pkg::MUL_C_W-1:0] addend,
   output logic [thcm_pkg::MUL_P_W-1:0] result
);

   logic [thcm_pkg::MUL_A_W+thcm_pkg::MUL_B_W-1:0] product;

   assign product = op_a * op_b;
   assign result  = thcm_pkg::MUL_P_W'(product) + thcm_pkg::MUL_P_W'(addend);

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for the thruster command mixer: directed edges, then random commands.
module tb;

   // Calibration lines in Q8.16: duty' = (offset + gain * duty) >> 16
   localparam int EAST_OFFSET  = 2684998;
   localparam int EAST_GAIN    = 67020;
   localparam int WEST_OFFSET  = 0;
   localparam int WEST_GAIN    = 65536;
   localparam int NSWAY_OFFSET = 2757165;
   localparam int NSWAY_GAIN   = 52545;
   localparam int SSWAY_OFFSET = 3349270;
   localparam int SSWAY_GAIN   = 60615;
   localparam int NUP_OFFSET   = 944540;
   localparam int NUP_GAIN     = 58615;
   localparam int SUP_OFFSET   = 1143962;
   localparam int SUP_GAIN     = 60823;

   localparam int DUTY_LIMIT  = 255;
   localparam int UP_SCALE    = 73;
   localparam int LEVEL_SCALE = 53;

   // Index past the register list; the block must ignore writes to it
   localparam logic [thcm_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   localparam int SETTING_PHASES   = 10;
   localparam int RANDOM_PER_PHASE = 150;
   localparam int SETTLE_CYCLES    = 12;
   localparam int RUN_LIMIT        = 2000000;

   typedef struct packed {
      logic [1:0] pair;
      logic [7:0] first_duty;
      logic       first_dir;
      logic [7:0] second_duty;
      logic       second_dir;
   } drive_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic signed [8:0] magnitude;
      bit                typed;
      drive_type         want;
   } cmd_row_type;

   // Directed edges. Rows with typed set carry a drive that is obvious by hand
   // (zero duty, full-scale forward at reset settings); the rest go to the predictor.
   localparam int DIRECTED_COUNT = 25;
   localparam cmd_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // zero turn after reset: heading forward, so the sway pair is chosen
      '{thcm_pkg::MODE_TURN, 9'sd0, 1'b1,
        '{thcm_pkg::PAIR_SWAY, 8'd255, 1'b1, 8'd255, 1'b0}},
      '{thcm_pkg::MODE_FORWARD, 9'sd0, 1'b1,
        '{thcm_pkg::PAIR_EAST_WEST, 8'd255, 1'b0, 8'd255, 1'b0}},
      '{thcm_pkg::MODE_FORWARD, 9'sd255, 1'b1,
        '{thcm_pkg::PAIR_EAST_WEST, 8'd10, 1'b1, 8'd55, 1'b1}},
      // most negative code saturates to -255
      '{thcm_pkg::MODE_FORWARD, 9'h100, 1'b1,
        '{thcm_pkg::PAIR_EAST_WEST, 8'd10, 1'b0, 8'd55, 1'b0}},
      '{thcm_pkg::MODE_FORWARD, -9'sd255, 1'b0, '0},
      // scaled level still zero: sum equals the minimum, duty forced to zero
      '{thcm_pkg::MODE_FORWARD, 9'sd4, 1'b1,
        '{thcm_pkg::PAIR_EAST_WEST, 8'd255, 1'b1, 8'd255, 1'b1}},
      '{thcm_pkg::MODE_FORWARD, 9'sd5, 1'b0, '0},
      '{thcm_pkg::MODE_SIDEWARD, 9'sd255, 1'b0, '0},
      '{thcm_pkg::MODE_SIDEWARD, -9'sd255, 1'b0, '0},
      // zero sideward leaves the heading alone
      '{thcm_pkg::MODE_SIDEWARD, 9'sd0, 1'b1,
        '{thcm_pkg::PAIR_SWAY, 8'd255, 1'b0, 8'd255, 1'b0}},
      '{thcm_pkg::MODE_TURN, 9'sd100, 1'b0, '0},
      // nonzero sideward clears the heading even with zero duty
      '{thcm_pkg::MODE_SIDEWARD, 9'sd1, 1'b1,
        '{thcm_pkg::PAIR_SWAY, 8'd255, 1'b1, 8'd255, 1'b1}},
      '{thcm_pkg::MODE_TURN, 9'sd100, 1'b0, '0},
      '{thcm_pkg::MODE_TURN, -9'sd100, 1'b0, '0},
      '{thcm_pkg::MODE_TURN, 9'sd0, 1'b1,
        '{thcm_pkg::PAIR_EAST_WEST, 8'd255, 1'b0, 8'd255, 1'b1}},
      '{thcm_pkg::MODE_TURN, 9'sd255, 1'b0, '0},
      '{thcm_pkg::MODE_UPWARD, 9'sd255, 1'b0, '0},
      '{thcm_pkg::MODE_UPWARD, 9'h100, 1'b0, '0},
      '{thcm_pkg::MODE_UPWARD, 9'sd0, 1'b1,
        '{thcm_pkg::PAIR_VERTICAL, 8'd255, 1'b0, 8'd255, 1'b0}},
      '{thcm_pkg::MODE_UPWARD, 9'sd3, 1'b1,
        '{thcm_pkg::PAIR_VERTICAL, 8'd255, 1'b1, 8'd255, 1'b1}},
      '{thcm_pkg::MODE_UPWARD, -9'sd3, 1'b1,
        '{thcm_pkg::PAIR_VERTICAL, 8'd255, 1'b0, 8'd255, 1'b0}},
      '{thcm_pkg::MODE_UPWARD, 9'sd4, 1'b0, '0},
      // nonzero forward sets the heading again
      '{thcm_pkg::MODE_FORWARD, 9'sd1, 1'b1,
        '{thcm_pkg::PAIR_EAST_WEST, 8'd255, 1'b1, 8'd255, 1'b1}},
      '{thcm_pkg::MODE_TURN, -9'sd255, 1'b0, '0},
      '{thcm_pkg::MODE_TURN, 9'sd255, 1'b0, '0}
   };

   logic                            clock;
   logic                            reset;
   logic                            csr_write_en;
   logic [thcm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [thcm_pkg::CSR_DATA_W-1:0] csr_write_data;

   thcm_req_if req_ch ();
   thcm_rsp_if rsp_ch ();

   thruster_command_mixer_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Mirror of the control registers and the heading flag
   int cfg_min_upward;
   int cfg_south_bias;
   int cfg_min_sideward;
   int cfg_min_forward;
   int cfg_min_turn_forward;
   int cfg_min_turn_sideward;
   int cfg_buoyancy;
   bit heading_forward;

   drive_type drive_queue[$];

   int  mismatches;
   int  commands_sent;
   int  results_checked;
   int  settings_applied;
   bit  steady_flow;

   // Free-running clock, period 4
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int clip255(input int v);
      if (v > 255) return 255;
      if (v < -255) return -255;
      return v;
   endfunction

   // Scale the level, add the minimum, calibrate only above the minimum, clamp, invert
   function automatic logic [7:0] inverted_duty(input int value, input int scale,
         input int minimum, input int cal_offset_q, input int cal_gain_q, input int bias);
      int level;
      int sum;
      int duty;
      level = (value < 0) ? -value : value;
      sum = level * scale / 255 + minimum;
      duty = 0;
      if (sum > minimum)
         duty = (cal_offset_q + cal_gain_q * sum) / 65536 + bias;
      if (duty < 0) duty = 0;
      if (duty > DUTY_LIMIT) duty = DUTY_LIMIT;
      return 8'(DUTY_LIMIT - duty);
   endfunction

   // Work out the pair drive for one command and advance the heading flag
   function automatic drive_type predict_drive(input logic [1:0] mode,
         input logic signed [8:0] raw);
      drive_type d;
      int        m;
      int        lift;
      bit        pos;
      m = clip255(int'(raw));
      pos = (m > 0);
      case (mode)
         thcm_pkg::MODE_FORWARD: begin
            d.pair = thcm_pkg::PAIR_EAST_WEST;
            d.first_duty = inverted_duty(m, LEVEL_SCALE, cfg_min_forward,
                                         EAST_OFFSET, EAST_GAIN, 0);
            d.second_duty = inverted_duty(m, LEVEL_SCALE, cfg_min_forward,
                                          WEST_OFFSET, WEST_GAIN, 0);
            d.first_dir = pos;
            d.second_dir = pos;
            if (m != 0) heading_forward = 1'b1;
         end
         thcm_pkg::MODE_SIDEWARD: begin
            d.pair = thcm_pkg::PAIR_SWAY;
            d.first_duty = inverted_duty(m, LEVEL_SCALE, cfg_min_sideward,
                                         NSWAY_OFFSET, NSWAY_GAIN, 0);
            d.second_duty = inverted_duty(m, LEVEL_SCALE, cfg_min_sideward,
                                          SSWAY_OFFSET, SSWAY_GAIN, 0);
            d.first_dir = pos;
            d.second_dir = pos;
            if (m != 0) heading_forward = 1'b0;
         end
         thcm_pkg::MODE_UPWARD: begin
            lift = clip255(m + cfg_buoyancy);
            d.pair = thcm_pkg::PAIR_VERTICAL;
            d.first_duty = inverted_duty(lift, UP_SCALE, cfg_min_upward,
                                         NUP_OFFSET, NUP_GAIN, 0);
            d.second_duty = inverted_duty(lift, UP_SCALE, cfg_min_upward,
                                          SUP_OFFSET, SUP_GAIN, cfg_south_bias);
            d.first_dir = (lift > 0);
            d.second_dir = (lift > 0);
         end
         default: begin
            if (heading_forward) begin
               d.pair = thcm_pkg::PAIR_SWAY;
               d.first_duty = inverted_duty(m, LEVEL_SCALE, cfg_min_turn_sideward,
                                            NSWAY_OFFSET, NSWAY_GAIN, 0);
               d.second_duty = inverted_duty(m, LEVEL_SCALE, cfg_min_turn_sideward,
                                             SSWAY_OFFSET, SSWAY_GAIN, 0);
               d.first_dir = !pos;
               d.second_dir = pos;
            end else begin
               d.pair = thcm_pkg::PAIR_EAST_WEST;
               d.first_duty = inverted_duty(m, LEVEL_SCALE, cfg_min_turn_forward,
                                            EAST_OFFSET, EAST_GAIN, 0);
               d.second_duty = inverted_duty(m, LEVEL_SCALE, cfg_min_turn_forward,
                                             WEST_OFFSET, WEST_GAIN, 0);
               d.first_dir = pos;
               d.second_dir = !pos;
            end
         end
      endcase
      return d;
   endfunction

   // Decode a register write the way the block does: 8-bit fields drop bit 8,
   // 9-bit fields are signed; anything past the list is dropped
   function automatic void apply_csr(input logic [thcm_pkg::CSR_IDX_W-1:0] idx,
         input logic [thcm_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         thcm_pkg::CSR_MIN_UPWARD:        cfg_min_upward = int'(data[7:0]);
         thcm_pkg::CSR_SOUTH_UP_BIAS:     cfg_south_bias = int'($signed(data));
         thcm_pkg::CSR_MIN_SIDEWARD:      cfg_min_sideward = int'(data[7:0]);
         thcm_pkg::CSR_MIN_FORWARD:       cfg_min_forward = int'(data[7:0]);
         thcm_pkg::CSR_MIN_TURN_FORWARD:  cfg_min_turn_forward = int'(data[7:0]);
         thcm_pkg::CSR_MIN_TURN_SIDEWARD: cfg_min_turn_sideward = int'(data[7:0]);
         thcm_pkg::CSR_BUOYANCY_OFFSET:   cfg_buoyancy = int'($signed(data));
         default: ;
      endcase
   endfunction

   // Drive one register write on the next falling edge; the caller drops the enable
   task automatic write_csr(input logic [thcm_pkg::CSR_IDX_W-1:0] idx,
         input logic [thcm_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      apply_csr(idx, data);
   endtask

   task automatic program_setting(input int up, input int bias, input int side,
         input int fwd, input int turn_fwd, input int turn_side, input int buoy);
      write_csr(thcm_pkg::CSR_MIN_UPWARD, 9'(up));
      write_csr(thcm_pkg::CSR_SOUTH_UP_BIAS, 9'(bias));
      write_csr(thcm_pkg::CSR_MIN_SIDEWARD, 9'(side));
      write_csr(thcm_pkg::CSR_MIN_FORWARD, 9'(fwd));
      write_csr(thcm_pkg::CSR_MIN_TURN_FORWARD, 9'(turn_fwd));
      write_csr(thcm_pkg::CSR_MIN_TURN_SIDEWARD, 9'(turn_side));
      write_csr(thcm_pkg::CSR_BUOYANCY_OFFSET, 9'(buoy));
      @(negedge clock);
      csr_write_en = 1'b0;
      settings_applied++;
   endtask

   // Drop valid and hold until every outstanding drive has come back
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (drive_queue.size() != 0) @(posedge clock);
   endtask

   // Present one command after a random gap, wait for its transfer and log
   // the drive it must produce. Valid stays high for a back-to-back follower.
   task automatic send_cmd(input logic [1:0] mode, input logic signed [8:0] magnitude,
         input bit typed, input drive_type typed_want);
      int        gap;
      drive_type predicted;
      gap = steady_flow ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.mode = mode;
      req_ch.magnitude = magnitude;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = predict_drive(mode, magnitude);
      drive_queue.push_back(typed ? typed_want : predicted);
      commands_sent++;
   endtask

   // Mostly full-range codes, with a share of tiny levels (zero-duty region) and extremes
   function automatic logic signed [8:0] draw_magnitude();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 9'h100;
               1: return -9'sd255;
               2: return 9'sd255;
               default: return 9'sd0;
            endcase
         end
         1, 2, 3: return 9'(int'($urandom_range(0, 16)) - 8);
         default: return 9'($urandom_range(0, 511));
      endcase
   endfunction

   function automatic int draw_unsigned_reg();
      return int'($urandom_range(0, 255));
   endfunction

   function automatic int draw_signed_reg();
      return int'($urandom_range(0, 510)) - 255;
   endfunction

   // Result side: hold ready low at random before each transfer, never in steady stretches
   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 3);
         repeat (stall) begin
            @(negedge clock);
            rsp_ch.ready = 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   // Compare every transferred drive against the oldest one still owed
   always @(posedge clock) begin : drive_check
      drive_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (drive_queue.size() == 0) begin
            $error("unexpected result transfer: pair %0d", rsp_ch.thruster_pair);
            mismatches++;
         end else begin
            want = drive_queue.pop_front();
            results_checked++;
            if (rsp_ch.thruster_pair !== want.pair) begin
               $error("thruster_pair: expected %0d, got %0d",
                      want.pair, rsp_ch.thruster_pair);
               mismatches++;
            end
            if (rsp_ch.first_duty_inverted !== want.first_duty) begin
               $error("first_duty_inverted: expected %0d, got %0d",
                      want.first_duty, rsp_ch.first_duty_inverted);
               mismatches++;
            end
            if (rsp_ch.first_direction !== want.first_dir) begin
               $error("first_direction: expected %0d, got %0d",
                      want.first_dir, rsp_ch.first_direction);
               mismatches++;
            end
            if (rsp_ch.second_duty_inverted !== want.second_duty) begin
               $error("second_duty_inverted: expected %0d, got %0d",
                      want.second_duty, rsp_ch.second_duty_inverted);
               mismatches++;
            end
            if (rsp_ch.second_direction !== want.second_dir) begin
               $error("second_direction: expected %0d, got %0d",
                      want.second_dir, rsp_ch.second_direction);
               mismatches++;
            end
         end
      end
   end

   // Hard stop in case a handshake never completes
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int n;
      // Hold every input at a known value under reset
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = thcm_pkg::CSR_MIN_UPWARD;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.mode = thcm_pkg::MODE_FORWARD;
      req_ch.magnitude = '0;
      steady_flow = 1'b0;
      mismatches = 0;
      commands_sent = 0;
      results_checked = 0;
      settings_applied = 0;
      // Register values and heading after reset
      cfg_min_upward = 80;
      cfg_south_bias = -35;
      cfg_min_sideward = 147;
      cfg_min_forward = 147;
      cfg_min_turn_forward = 60;
      cfg_min_turn_sideward = 80;
      cfg_buoyancy = 0;
      heading_forward = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table under reset settings
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_cmd(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].magnitude,
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

      // Random phases, each under a fresh register setting written while idle
      for (phase = 0; phase < SETTING_PHASES; phase++) begin
         drain_results();
         case (phase)
            // all maxima: calibrated duties overflow, buoyancy saturates the lift
            0: program_setting(255, 255, 255, 255, 255, 255, 255);
            // all minima: south-up bias drives the duty negative
            1: program_setting(0, -255, 0, 0, 0, 0, -255);
            2: begin
               write_csr(CSR_UNUSED_IDX, 9'h1FF);
               program_setting(80, -35, 147, 147, 60, 80, 0);
            end
            default: program_setting(draw_unsigned_reg(), draw_signed_reg(),
                                     draw_unsigned_reg(), draw_unsigned_reg(),
                                     draw_unsigned_reg(), draw_unsigned_reg(),
                                     draw_signed_reg());
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Switch between idling and back-to-back stretches now and then
            if (n % 50 == 0) steady_flow = ($urandom_range(0, 3) == 0);
            // Occasionally hold the sender until the pipeline is empty
            if ($urandom_range(0, 59) == 0) drain_results();
            send_cmd(2'($urandom_range(0, 3)), draw_magnitude(), 1'b0, '0);
         end
      end

      // Let the tail drain, then wait out the settle period for stray transfers
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d commands of all four kinds, directed edges then random,",
               commands_sent);
      $display("under %0d register settings; %0d drives compared field by field.",
               settings_applied + 1, results_checked);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
